FILE: hw/rtl/imu_fir_delta_integrator_assert.svh
// Assertion macros for the IMU FIR / delta integrator block.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef IMU_FIR_DELTA_INTEGRATOR_ASSERT_SVH
`define IMU_FIR_DELTA_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is high
`define IFDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds while reset is high
`define IFDI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFDI_ASSERT(lbl, prop, msg)
`define IFDI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/ifdi_pkg.sv
// Shared types and constants of the IMU FIR / delta integrator.
// No dependencies; imported by every module of the block.
package ifdi_pkg;

  // default build parameters
  localparam int TAPS_DEF        = 4;
  localparam int FRAME_LEN_DEF   = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed formats
  localparam int AXES         = 3;
  localparam int AXIS_BITS    = 2;
  localparam int NUM_COEF     = 4;
  localparam int TAP_IDX_BITS = 2;
  localparam int COEF_BITS    = 18;
  localparam int SCALE_BITS   = 32;
  localparam int OUT_BITS     = 32;
  localparam int OUT_FIELDS   = 2 * AXES;
  localparam int OUT_IDX_BITS = 3;
  localparam int VAL_BITS     = 64;
  localparam int MUL_BITS     = 33;
  localparam int PROD_BITS    = 2 * MUL_BITS;
  localparam int CARRY_BITS   = 33;
  localparam int CNT_BITS     = 4;

  // saturation bounds and rounding bias of the Q.48 to Q.16 step
  localparam logic signed [PROD_BITS-1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [PROD_BITS-1:0] SAT_LO = -66'sd2147483648;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_BITS-1:0] OUT_MIN = 32'h8000_0000;
  localparam logic [64:0] ROUND_HALF = 65'h0_8000_0000;

  // last step of the scaling sequence: two multiplies per output plus one
  localparam logic [CNT_BITS-1:0] SCL_LAST = CNT_BITS'(2 * OUT_FIELDS);

  // register map
  localparam int APB_DATA_BITS = 32;
  localparam int ADDR_BITS     = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_0     = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_1     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_2     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_3     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_SCALE = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_RATE_SCALE = 3'd5;

  localparam logic [COEF_BITS-1:0]  COEF0_RST      = 18'd65536;
  localparam logic [SCALE_BITS-1:0] STEP_SCALE_RST = 32'd374856;
  localparam logic [SCALE_BITS-1:0] RATE_SCALE_RST = 32'd74961321;

  // configuration seen by the datapath
  typedef struct packed {
    logic [NUM_COEF-1:0][COEF_BITS-1:0] coef;
    logic [SCALE_BITS-1:0]              step_scale;
    logic [SCALE_BITS-1:0]              rate_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_SUM,
    ST_WAIT,
    ST_SCALE
  } state_t;

  // what the product register holds
  typedef enum logic [1:0] {
    PK_NONE,
    PK_FIR,
    PK_LO,
    PK_HI
  } prod_kind_t;

  // sequencer to datapath
  typedef struct packed {
    logic                     hist_wr;
    logic                     acc_clr;
    logic                     fir_issue;
    logic [TAP_IDX_BITS-1:0]  fir_tap;
    logic [AXIS_BITS-1:0]     fir_axis;
    logic                     ptr_adv;
    logic                     sum_upd;
    logic                     sum_clr;
    logic                     scl_lo;
    logic                     scl_hi;
    logic [OUT_IDX_BITS-1:0]  scl_idx;
    logic                     out_set;
  } ctrl_t;

endpackage

FILE: hw/rtl/ifdi_regs.sv
// APB register file: tap weights and the two output scales.
// Depends on ifdi_pkg.
module ifdi_regs import ifdi_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic                    wr;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_BITS-1:2];

  // register writes; weights beyond the tap count are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef       <= {{((NUM_COEF-1)*COEF_BITS){1'b0}}, COEF0_RST};
      cfg.step_scale <= STEP_SCALE_RST;
      cfg.rate_scale <= RATE_SCALE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3: begin
          if (32'(idx) < TAPS) begin
            cfg.coef[idx[TAP_IDX_BITS-1:0]] <= pwdata[COEF_BITS-1:0];
          end
        end
        REG_STEP_SCALE: cfg.step_scale <= pwdata[SCALE_BITS-1:0];
        REG_RATE_SCALE: cfg.rate_scale <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_COEF_0: prdata = {{(APB_DATA_BITS-COEF_BITS){1'b0}}, cfg.coef[0]};
      REG_COEF_1: prdata = {{(APB_DATA_BITS-COEF_BITS){1'b0}}, cfg.coef[1]};
      REG_COEF_2: prdata = {{(APB_DATA_BITS-COEF_BITS){1'b0}}, cfg.coef[2]};
      REG_COEF_3: prdata = {{(APB_DATA_BITS-COEF_BITS){1'b0}}, cfg.coef[3]};
      REG_STEP_SCALE: prdata = cfg.step_scale;
      REG_RATE_SCALE: prdata = cfg.rate_scale;
      default: prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ifdi_ctrl.sv
// Sequencer: walks the FIR taps, the frame sum update and the scaling steps
// over the shared multiplier. Depends on ifdi_pkg.
module ifdi_ctrl import ifdi_pkg::*; #(
  parameter int TAPS      = TAPS_DEF,
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   s_valid,
  output logic   s_ready,
  input  logic   out_busy,
  output ctrl_t  ctl,
  output state_t st
);

  localparam int ACT_TAPS = (TAPS < NUM_COEF) ? TAPS : NUM_COEF;
  localparam int NOPS     = ACT_TAPS * AXES;
  localparam int FC_BITS  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  state_t                  st_next;
  logic [CNT_BITS-1:0]     cnt;
  logic [TAP_IDX_BITS-1:0] tap;
  logic [AXIS_BITS-1:0]    axis;
  logic [FC_BITS-1:0]      fcnt;
  logic                    frame_end;

  assign frame_end = (fcnt == FC_BITS'(FRAME_LEN - 1));

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (s_valid) st_next = ST_FIR;
      ST_FIR:   if (cnt == CNT_BITS'(NOPS + 1)) st_next = ST_SUM;
      ST_SUM: begin
        if (!frame_end) begin
          st_next = ST_IDLE;
        end else if (out_busy) begin
          st_next = ST_WAIT;
        end else begin
          st_next = ST_SCALE;
        end
      end
      ST_WAIT:  if (!out_busy) st_next = ST_SCALE;
      ST_SCALE: if (cnt == SCL_LAST) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_ready       = (st == ST_IDLE);
    ctl           = '0;
    ctl.hist_wr   = (st == ST_IDLE) && s_valid;
    ctl.acc_clr   = (st == ST_IDLE) && s_valid;
    ctl.fir_issue = (st == ST_FIR) && (cnt < CNT_BITS'(NOPS));
    ctl.fir_tap   = tap;
    ctl.fir_axis  = axis;
    ctl.ptr_adv   = (st == ST_SUM);
    ctl.sum_upd   = (st == ST_SUM);
    ctl.scl_lo    = (st == ST_SCALE) && !cnt[0] && (cnt != SCL_LAST);
    ctl.scl_hi    = (st == ST_SCALE) && cnt[0];
    ctl.scl_idx   = cnt[CNT_BITS-1:1];
    ctl.out_set   = (st == ST_SCALE) && (cnt == SCL_LAST);
    ctl.sum_clr   = (st == ST_SCALE) && (cnt == SCL_LAST);
  end

  // state, step counter and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      cnt  <= '0;
      tap  <= '0;
      axis <= '0;
      fcnt <= '0;
    end else begin
      st  <= st_next;
      cnt <= (st_next != st) ? '0 : cnt + 1'b1;
      if (ctl.hist_wr) begin
        tap  <= '0;
        axis <= '0;
      end else if (ctl.fir_issue) begin
        if (axis == AXIS_BITS'(AXES - 1)) begin
          axis <= '0;
          tap  <= tap + 1'b1;
        end else begin
          axis <= axis + 1'b1;
        end
      end
      if (st == ST_SUM) begin
        fcnt <= frame_end ? '0 : fcnt + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ifdi_dp.sv
// Datapath: sample history memory, the shared 33x33 multiplier, FIR and frame
// accumulators, rounding/saturation and the output register. Depends on ifdi_pkg.
module ifdi_dp import ifdi_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_t                          ctl,
  input  cfg_t                           cfg,
  input  logic [AXES*SAMPLE_BITS-1:0]    in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [OUT_FIELDS*OUT_BITS-1:0] out_data
);

  localparam int IN_BITS   = AXES * SAMPLE_BITS;
  localparam int PTR_BITS  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SLOT_BITS = PTR_BITS + 1;
  localparam int FILT_BITS = SAMPLE_BITS + COEF_BITS + TAP_IDX_BITS;
  localparam int SUM_BITS  = FILT_BITS + $clog2(FRAME_LEN);

  // history memory, one row per time step holding all three axes
  logic [IN_BITS-1:0]  hist [TAPS];
  logic [TAPS-1:0]     hv;
  logic [PTR_BITS-1:0] wp;
  logic [PTR_BITS-1:0] rd_addr;
  logic [SLOT_BITS-1:0] slot_sum;
  logic [IN_BITS-1:0]  rd_row;
  logic                rd_ok;

  // pipeline tags
  logic                    s1_vld;
  logic [AXIS_BITS-1:0]    s1_axis;
  logic [TAP_IDX_BITS-1:0] s1_tap;
  prod_kind_t              pk;
  prod_kind_t              mul_kind;
  logic [AXIS_BITS-1:0]    p_axis;
  logic [OUT_IDX_BITS-1:0] p_idx;

  // multiplier
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [MUL_BITS-1:0]    mul_a;
  logic signed [MUL_BITS-1:0]    mul_b;
  logic signed [PROD_BITS-1:0]   prod;

  // scaling operands and result
  logic signed [VAL_BITS-1:0]  val;
  logic [SCALE_BITS-1:0]       scl;
  logic [64:0]                 lo_sum;
  logic [CARRY_BITS-1:0]       carry;
  logic signed [PROD_BITS-1:0] res;
  logic [OUT_BITS-1:0]         res_sat;

  // accumulators
  logic signed [FILT_BITS-1:0] acc  [AXES];
  logic signed [SUM_BITS-1:0]  fsum [AXES];
  logic [OUT_FIELDS-1:0][OUT_BITS-1:0] out_reg;

  assign out_data = out_reg;

  // ring slot of the sample that is fir_tap steps old
  always_comb begin
    slot_sum = {1'b0, wp} + SLOT_BITS'(TAPS) - SLOT_BITS'(ctl.fir_tap);
    if (slot_sum >= SLOT_BITS'(TAPS)) begin
      slot_sum = slot_sum - SLOT_BITS'(TAPS);
    end
    rd_addr = slot_sum[PTR_BITS-1:0];
  end

  // history memory: write on accept, registered read
  always_ff @(posedge clk) begin
    if (ctl.hist_wr) begin
      hist[wp] <= in_data;
    end
    rd_row <= hist[rd_addr];
    rd_ok  <= hv[rd_addr];
  end

  // sample of the current axis; a never written row reads as zero
  always_comb begin
    unique case (s1_axis)
      2'd0:    samp = rd_row[0*SAMPLE_BITS +: SAMPLE_BITS];
      2'd1:    samp = rd_row[1*SAMPLE_BITS +: SAMPLE_BITS];
      default: samp = rd_row[2*SAMPLE_BITS +: SAMPLE_BITS];
    endcase
    if (!rd_ok) begin
      samp = '0;
    end
  end

  // value and scale for the output being scaled
  always_comb begin
    if (ctl.scl_idx < OUT_IDX_BITS'(AXES)) begin
      val = VAL_BITS'(fsum[ctl.scl_idx[AXIS_BITS-1:0]]);
      scl = cfg.step_scale;
    end else begin
      val = VAL_BITS'(acc[AXIS_BITS'(ctl.scl_idx - OUT_IDX_BITS'(AXES))]);
      scl = cfg.rate_scale;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    priority if (s1_vld) begin
      mul_a    = MUL_BITS'(samp);
      mul_b    = MUL_BITS'($signed(cfg.coef[s1_tap]));
      mul_kind = PK_FIR;
    end else if (ctl.scl_lo) begin
      mul_a    = {1'b0, val[31:0]};
      mul_b    = {1'b0, scl};
      mul_kind = PK_LO;
    end else if (ctl.scl_hi) begin
      mul_a    = {val[VAL_BITS-1], val[VAL_BITS-1:32]};
      mul_b    = {1'b0, scl};
      mul_kind = PK_HI;
    end else begin
      mul_a    = '0;
      mul_b    = '0;
      mul_kind = PK_NONE;
    end
  end

  // round half up on the low partial product, then add the high one and clamp
  always_comb begin
    lo_sum = {1'b0, prod[63:0]} + ROUND_HALF;
    res    = prod + $signed({1'b0, carry});
    if (res > SAT_HI) begin
      res_sat = OUT_MAX;
    end else if (res < SAT_LO) begin
      res_sat = OUT_MIN;
    end else begin
      res_sat = res[OUT_BITS-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= '0;
      wp        <= '0;
      s1_vld    <= 1'b0;
      pk        <= PK_NONE;
      out_valid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        fsum[a] <= '0;
      end
    end else begin
      if (ctl.hist_wr) begin
        hv[wp] <= 1'b1;
      end
      if (ctl.ptr_adv) begin
        wp <= (wp == PTR_BITS'(TAPS - 1)) ? '0 : wp + 1'b1;
      end
      s1_vld <= ctl.fir_issue;
      pk     <= mul_kind;
      if (ctl.out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // frame sums
      for (int a = 0; a < AXES; a++) begin
        if (ctl.sum_clr) begin
          fsum[a] <= '0;
        end else if (ctl.sum_upd) begin
          fsum[a] <= fsum[a] + SUM_BITS'(acc[a]);
        end
      end
    end
  end

  // payload: tags, product, carry, filter accumulators, outputs
  always_ff @(posedge clk) begin
    s1_axis <= ctl.fir_axis;
    s1_tap  <= ctl.fir_tap;
    prod    <= mul_a * mul_b;
    p_axis  <= s1_axis;
    p_idx   <= ctl.scl_idx;
    if (ctl.acc_clr) begin
      for (int a = 0; a < AXES; a++) begin
        acc[a] <= '0;
      end
    end else if (pk == PK_FIR) begin
      acc[p_axis] <= acc[p_axis] + $signed(prod[FILT_BITS-1:0]);
    end
    if (pk == PK_LO) begin
      carry <= lo_sum[64:32];
    end
    if (pk == PK_HI) begin
      out_reg[p_idx] <= res_sat;
    end
  end

endmodule

FILE: hw/rtl/imu_fir_delta_integrator.sv
// IMU FIR / delta integrator top level: APB registers, sequencer, datapath.
// Depends on ifdi_pkg, ifdi_regs, ifdi_ctrl, ifdi_dp and the assertion header.
//
// Usage: one request on the input stream carries one x/y/z sample. Each axis
// runs through a FIR filter (up to four weighted taps) and the filtered values
// are summed over a frame of FRAME_LEN requests. On the last request of a
// frame one result request leaves on the output stream: the frame sums times
// step_scale and the last filtered values times rate_scale, each rounded half
// up and clamped to signed 32 bits. Other requests produce no result.
// Flow: one multiplier does all products, one per cycle. A request runs its
// FIR products, then the frame sum update, before the next request is taken;
// a frame's last request also runs the scaling steps, after which its result
// shows valid. A result waiting in the output register does not block input;
// only the next frame's scaling waits until the receiver has taken it.
// Reset: history, frame sums and frame position clear, registers return to
// their defaults (unit weight on the current sample), no result is pending.
// Registers must be written over APB only while the block is idle; the block
// itself does not enforce it.
`include "imu_fir_delta_integrator_assert.svh"
module imu_fir_delta_integrator import ifdi_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_BITS    = AXES * SAMPLE_BITS,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // low to high: sample_x, sample_y, sample_z, zero pad to bytes
  input  logic [IN_W-1:0]                s_axis_tdata,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // low to high: delta_x, delta_y, delta_z, rate_x, rate_y, rate_z
  output logic [OUT_FIELDS*OUT_BITS-1:0] m_axis_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ADDR_BITS-1:0]           paddr,
  input  logic [APB_DATA_BITS-1:0]       pwdata,
  output logic [APB_DATA_BITS-1:0]       prdata,
  output logic                           pready
);

  cfg_t   cfg;
  ctrl_t  ctl;
  state_t st;

  ifdi_regs #(
    .TAPS (TAPS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifdi_ctrl #(
    .TAPS      (TAPS),
    .FRAME_LEN (FRAME_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .out_busy (m_axis_tvalid),
    .ctl      (ctl),
    .st       (st)
  );

  ifdi_dp #(
    .TAPS        (TAPS),
    .FRAME_LEN   (FRAME_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .in_data   (s_axis_tdata[IN_BITS-1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // checks
  `IFDI_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
  `IFDI_ASSERT(a_scale_out_free, st == ST_SCALE |-> !m_axis_tvalid, "scaling over a pending result")
  `IFDI_ASSERT(a_result_from_scale, $rose(m_axis_tvalid) |-> $past(st) == ST_SCALE, "result outside scaling")
  `IFDI_ASSERT_RST(a_no_result_after_reset, rst |=> !m_axis_tvalid, "result pending after reset")

endmodule

FILE: tb/sv/tb_imu_fir_delta_integrator.sv
// Self-checking testbench for imu_fir_delta_integrator: streams x/y/z samples in,
// predicts every frame result in a local filter-and-integrate model and checks it.
// Depends on ifdi_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_imu_fir_delta_integrator;
  import ifdi_pkg::*;

  localparam int IN_W         = AXES * SAMPLE_BITS_DEF;
  localparam int RES_W        = OUT_FIELDS * OUT_BITS;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 400000;

  // indexes past the register list, written to show they are ignored
  localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] z;
    logic signed [SAMPLE_BITS_DEF-1:0] y;
    logic signed [SAMPLE_BITS_DEF-1:0] x;
  } imu_sample_t;

  // low to high: delta_x, delta_y, delta_z, rate_x, rate_y, rate_z
  typedef logic [RES_W-1:0] imu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // low to high: sample_x, sample_y, sample_z
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // low to high: delta_x, delta_y, delta_z, rate_x, rate_y, rate_z
  logic [RES_W-1:0]  m_axis_tdata;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]     paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  imu_fir_delta_integrator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // mirror of the register file
  logic signed [COEF_BITS-1:0] tap_weight [TAPS_DEF];
  logic [SCALE_BITS-1:0]       step_k;
  logic [SCALE_BITS-1:0]       rate_k;

  // mirror of the filter history and frame integrators
  logic signed [SAMPLE_BITS_DEF-1:0] hist [TAPS_DEF][AXES];
  int                                hist_ptr;
  longint                            frame_acc [AXES];
  int                                frame_pos;

  imu_sample_t samples_pending [$];
  imu_result_t deltas_due [$];
  imu_sample_t held_sample;
  imu_result_t want;
  int          samples_queued;
  int          samples_taken;
  int          send_gap;
  int          recv_stall;
  int          mismatches;
  int          cycles;
  bit          idle_on;

  string field_name [OUT_FIELDS] = '{"delta_x", "delta_y", "delta_z",
                                     "rate_x", "rate_y", "rate_z"};

  initial begin
    forever #1 clk = ~clk;
  end

  // Q.48 product to Q15.16: round half up, clamp to signed 32 bits
  function automatic logic [OUT_BITS-1:0] scale_q16(input longint v,
                                                     input logic [SCALE_BITS-1:0] k);
    logic signed [97:0] p;
    p = v * $signed({1'b0, k});
    p = (p + 98'sd2147483648) >>> 32;
    if (p > 98'sd2147483647)
      return OUT_MAX;
    else if (p < -98'sd2147483648)
      return OUT_MIN;
    return p[OUT_BITS-1:0];
  endfunction

  // one accepted sample through the filters; queues a result on frame end
  task automatic integrate_sample(input imu_sample_t s);
    longint      filt [AXES];
    int          slot;
    imu_result_t r;
    hist[hist_ptr][0] = s.x;
    hist[hist_ptr][1] = s.y;
    hist[hist_ptr][2] = s.z;
    for (int a = 0; a < AXES; a++) begin
      filt[a] = 0;
      for (int i = 0; i < TAPS_DEF; i++) begin
        slot = (hist_ptr + TAPS_DEF - i) % TAPS_DEF;
        filt[a] += longint'(hist[slot][a]) * longint'(tap_weight[i]);
      end
      frame_acc[a] += filt[a];
    end
    hist_ptr = (hist_ptr + 1) % TAPS_DEF;
    frame_pos++;
    if (frame_pos == FRAME_LEN_DEF) begin
      for (int a = 0; a < AXES; a++) begin
        r[a*OUT_BITS +: OUT_BITS]        = scale_q16(frame_acc[a], step_k);
        r[(AXES+a)*OUT_BITS +: OUT_BITS] = scale_q16(filt[a], rate_k);
        frame_acc[a] = 0;
      end
      deltas_due = {deltas_due, r};
      frame_pos = 0;
    end
  endtask

  // APB write: setup cycle, access cycle, register updates on the access edge
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [APB_DATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3: begin
        tap_weight[idx[TAP_IDX_BITS-1:0]] = value[COEF_BITS-1:0];
      end
      REG_STEP_SCALE: step_k = value;
      REG_RATE_SCALE: rate_k = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3,
                            input logic [31:0] step, input logic [31:0] rate);
    write_reg(REG_COEF_0, c0);
    write_reg(REG_COEF_1, c1);
    write_reg(REG_COEF_2, c2);
    write_reg(REG_COEF_3, c3);
    write_reg(REG_STEP_SCALE, step);
    write_reg(REG_RATE_SCALE, rate);
  endtask

  task automatic queue_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
    imu_sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    samples_pending = {samples_pending, s};
    samples_queued++;
  endtask

  // mostly full-range values, some extremes and some near zero
  function automatic logic [15:0] pick_value();
    unique case ($urandom_range(0, 9))
      0: begin
        unique case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++)
      queue_sample(pick_value(), pick_value(), pick_value());
  endtask

  // wait for all requests taken and results back, then let the pipeline empty
  task automatic wait_drained();
    while (samples_taken != samples_queued || deltas_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: pops pending samples, random idle bursts between requests
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        integrate_sample(held_sample);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (samples_pending.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else begin
          held_sample = samples_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= held_sample;
        end
      end
    end
  end

  // output monitor: checks each result request, random stall bursts on tready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (deltas_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = deltas_due.pop_front();
          for (int f = 0; f < OUT_FIELDS; f++) begin
            if (m_axis_tdata[f*OUT_BITS +: OUT_BITS] !== want[f*OUT_BITS +: OUT_BITS]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%s mismatch: expected %h, got %h", field_name[f],
                         want[f*OUT_BITS +: OUT_BITS], m_axis_tdata[f*OUT_BITS +: OUT_BITS]);
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [15:0] ext [4];
    ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    tap_weight = '{default: '0};
    tap_weight[0] = COEF0_RST;
    step_k = STEP_SCALE_RST;
    rate_k = RATE_SCALE_RST;
    hist = '{default: '0};
    hist_ptr = 0;
    frame_acc = '{default: 0};
    frame_pos = 0;
    samples_queued = 0;
    samples_taken = 0;
    mismatches = 0;
    cycles = 0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset weights: field extremes rotated across the axes, then random
    for (int k = 0; k < 20; k++)
      queue_sample(ext[k % 4], ext[(k + 1) % 4], ext[(k + 2) % 4]);
    queue_random(100);
    wait_drained();

    // weights 0-2 heaviest, full scales: both clamps, junk above register widths
    write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 32'h1234_5678);
    set_config(32'hFFF1_FFFF, 32'h0001_FFFF, 32'hABCE_0000, 32'hFFFC_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 20; k++) begin
      if (k < 10)
        queue_sample(16'h7FFF, 16'h8000, 16'h7FFF);
      else
        queue_sample(16'h8000, 16'h7FFF, 16'h0001);
    end
    queue_random(150);
    wait_drained();

    // all weights and scales zero
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_random(100);
    wait_drained();

    // most negative weights, smallest non-zero rate scale
    set_config(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
               32'hFFFF_FFFF, 32'd1);
    queue_random(150);
    wait_drained();

    // random settings, with and without idling
    for (int p = 0; p < 4; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random(150);
      wait_drained();
    end

    // back to the reset settings, no idling to the end
    idle_on = 1'b0;
    set_config(32'(COEF0_RST), 32'd0, 32'd0, 32'd0, STEP_SCALE_RST, RATE_SCALE_RST);
    queue_random(200);
    wait_drained();

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
